// ===== hw/rtl/ural_pkg.sv =====
// shared constants and types for the ultrasonic range averaging block
// no dependencies; imported by every module of the block
package ural_pkg;

  // burst length and field widths
  localparam int SAMPLE_COUNT = 3;
  localparam int ECHO_W       = 15;
  localparam int SUM_W        = 18;
  localparam int CNT_W        = 4;
  localparam int IDX_W        = 3;
  localparam int DIST_W       = 14;

  // fixed point scaling: distance = (avg * 1124) >> 12
  localparam int QUO_W        = 15;
  localparam int MUL_W        = 11;
  localparam int PROD_W       = QUO_W + MUL_W;
  localparam int SCALE_SHIFT  = 12;
  localparam logic [MUL_W-1:0] SCALE_MUL = MUL_W'(1124);

  // serial divider: one quotient bit per cycle
  localparam int DIV_STEPS    = SUM_W;
  localparam int STEP_W       = 5;

  // threshold register reset value
  localparam logic [DIST_W-1:0] THRESH_RESET = DIST_W'(480);

  // last position within a burst
  localparam logic [IDX_W-1:0] SAMPLE_LAST = IDX_W'(SAMPLE_COUNT - 1);

  // one finished burst handed from front to back
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] cnt;
  } burst_t;

  // queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== hw/rtl/ultrasonic_range_average_lock.sv =====
// top level of the ultrasonic range averaging block with forward lock
// depends on ural_pkg, ural_front, ural_fifo and ural_back
//
//   channel | handshake               | payload
//   --------+-------------------------+----------------------------------------
//   in      | in_valid / in_ready     | in_echo_us
//   out     | out_valid / out_ready   | out_distance, out_forward_locked,
//           |                         | out_sensor_healthy
//   cfg     | cfg_wr_en               | cfg_wr_data (distance threshold)
//
// the front takes one echo beat per cycle; the closing beat of a burst
// waits only when the two-entry burst queue is full
// the back takes one burst at a time: a load, 18 divider steps (one quotient
// bit each), one multiply and a load of the result register; a burst with
// every echo timed out skips the divide and the multiply
// a held result stalls the back, and the front once the queue is full
// synchronous reset clears all control
module ultrasonic_range_average_lock import ural_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [ECHO_W-1:0] in_echo_us,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DIST_W-1:0] out_distance,
  output logic              out_forward_locked,
  output logic              out_sensor_healthy,
  input  logic              cfg_wr_en,
  input  logic [DIST_W-1:0] cfg_wr_data
);

  logic    push;
  logic    pop;
  burst_t  push_data;
  burst_t  pop_data;
  q_stat_t q_stat;

  // burst accumulation
  ural_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_echo_us (in_echo_us),
    .q_stat     (q_stat),
    .push       (push),
    .push_data  (push_data)
  );

  // burst queue
  ural_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .q_stat    (q_stat)
  );

  // divide, scale and compare
  ural_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .q_stat             (q_stat),
    .pop_data           (pop_data),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_distance       (out_distance),
    .out_forward_locked (out_forward_locked),
    .out_sensor_healthy (out_sensor_healthy)
  );

`ifndef SYNTHESIS
  // no burst is written into a full queue
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_stat.full)
    else $error("burst pushed into full queue");

  // no burst is taken from an empty queue
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("burst popped from empty queue");

  // a failed burst reports zero distance and locks forward motion
  a_failed_burst: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_sensor_healthy) |-> (out_forward_locked && (out_distance == '0)))
    else $error("failed burst result malformed");

  // a push and a pop in one cycle leave the queue level unchanged
  a_level_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (push && pop) |=> ($stable(q_stat.full) && $stable(q_stat.empty)))
    else $error("queue level moved on push with pop");
`endif

endmodule

// ===== hw/rtl/ural_front.sv =====
// front end: accepts echo beats, sums the valid ones over a burst
// depends on ural_pkg; pushes one burst summary into the queue
module ural_front import ural_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [ECHO_W-1:0] in_echo_us,
  input  q_stat_t           q_stat,
  output logic              push,
  output burst_t            push_data
);

  logic [SUM_W-1:0] sum_r;
  logic [CNT_W-1:0] cnt_r;
  logic [IDX_W-1:0] idx_r;
  logic [SUM_W-1:0] sum_nxt;
  logic [CNT_W-1:0] cnt_nxt;
  logic             last;
  logic             hit;
  logic             accept;

  // only the closing beat of a burst needs queue space
  assign last     = (idx_r == SAMPLE_LAST);
  assign in_ready = !last || !q_stat.full;
  assign accept   = in_valid && in_ready;

  // a zero echo is a timeout and is not counted
  assign hit     = (in_echo_us != '0);
  assign sum_nxt = hit ? (sum_r + SUM_W'(in_echo_us)) : sum_r;
  assign cnt_nxt = hit ? (cnt_r + CNT_W'(1)) : cnt_r;

  assign push           = accept && last;
  assign push_data.sum  = sum_nxt;
  assign push_data.cnt  = cnt_nxt;

  // accumulators, cleared at the end of every burst
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      cnt_r <= '0;
      idx_r <= '0;
    end else if (accept) begin
      if (last) begin
        sum_r <= '0;
        cnt_r <= '0;
        idx_r <= '0;
      end else begin
        sum_r <= sum_nxt;
        cnt_r <= cnt_nxt;
        idx_r <= idx_r + IDX_W'(1);
      end
    end
  end

endmodule

// ===== hw/rtl/ural_fifo.sv =====
// two-entry queue of burst summaries between front and back
// depends on ural_pkg
module ural_fifo import ural_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  burst_t  push_data,
  input  logic    pop,
  output burst_t  pop_data,
  output q_stat_t q_stat
);

  burst_t     entries_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;

  assign q_stat.full  = (count_r == 2'd2);
  assign q_stat.empty = (count_r == 2'd0);
  assign pop_data     = entries_r[rd_ptr_r];

  // storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ===== hw/rtl/ural_back.sv =====
// back end: serial divide of the burst sum, scaling, threshold compare
// depends on ural_pkg; holds the threshold register and result register
module ural_back import ural_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [DIST_W-1:0] cfg_wr_data,
  input  q_stat_t           q_stat,
  input  burst_t            pop_data,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DIST_W-1:0] out_distance,
  output logic              out_forward_locked,
  output logic              out_sensor_healthy
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_LOAD
  } state_t;

  localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(DIV_STEPS - 1);

  state_t              state_r;
  logic [DIST_W-1:0]   thresh_r;
  logic [SUM_W-1:0]    quo_r;
  logic [CNT_W-1:0]    rem_r;
  logic [CNT_W-1:0]    div_r;
  logic [STEP_W-1:0]   step_r;
  logic                healthy_r;
  logic [PROD_W-1:0]   prod_r;
  logic                out_valid_r;
  logic [DIST_W-1:0]   out_dist_r;
  logic                out_lock_r;
  logic                out_health_r;

  logic [CNT_W:0]      rem_sh;
  logic [CNT_W:0]      rem_dif;
  logic                ge;
  logic [CNT_W-1:0]    rem_nxt;
  logic [SUM_W-1:0]    quo_nxt;
  logic [PROD_W-1:0]   prod;
  logic [DIST_W-1:0]   scaled_dist;
  logic                slot_free;
  logic                load_out;

  // restoring divide step, quotient bits shift in from the right
  assign rem_sh  = {rem_r, quo_r[SUM_W-1]};
  assign rem_dif = rem_sh - {1'b0, div_r};
  assign ge      = (rem_sh >= {1'b0, div_r});
  assign rem_nxt = ge ? rem_dif[CNT_W-1:0] : rem_sh[CNT_W-1:0];
  assign quo_nxt = {quo_r[SUM_W-2:0], ge};

  // scaling to 1/16 cm, product registered before the compare
  assign prod        = quo_r[QUO_W-1:0] * SCALE_MUL;
  assign scaled_dist = prod_r[PROD_W-1:SCALE_SHIFT];

  assign pop       = (state_r == ST_IDLE) && !q_stat.empty;
  assign slot_free = !out_valid_r || out_ready;
  assign load_out  = (state_r == ST_LOAD) && slot_free;

  assign out_valid          = out_valid_r;
  assign out_distance       = out_dist_r;
  assign out_forward_locked = out_lock_r;
  assign out_sensor_healthy = out_health_r;

  // sequencer, threshold and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      thresh_r    <= THRESH_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        thresh_r <= cfg_wr_data;
      end
      // result valid: set on load, dropped once the beat is taken
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (!q_stat.empty) begin
            quo_r     <= pop_data.sum;
            div_r     <= pop_data.cnt;
            rem_r     <= '0;
            step_r    <= '0;
            healthy_r <= (pop_data.cnt != '0);
            state_r   <= (pop_data.cnt != '0) ? ST_DIV : ST_LOAD;
          end
        end
        ST_DIV: begin
          rem_r  <= rem_nxt;
          quo_r  <= quo_nxt;
          step_r <= step_r + STEP_W'(1);
          if (step_r == DIV_LAST) begin
            state_r <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod_r  <= prod;
          state_r <= ST_LOAD;
        end
        ST_LOAD: begin
          if (slot_free) begin
            if (healthy_r) begin
              out_dist_r   <= scaled_dist;
              out_lock_r   <= (scaled_dist < thresh_r);
              out_health_r <= 1'b1;
            end else begin
              out_dist_r   <= '0;
              out_lock_r   <= 1'b1;
              out_health_r <= 1'b0;
            end
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== sim/ultrasonic_range_average_lock_tb.sv =====
// testbench for the ultrasonic range averaging block with forward lock
// self-checking: a burst predictor in a scoreboard class checks every result beat
// depends on ural_pkg and ultrasonic_range_average_lock
`timescale 1ns / 1ps

module ultrasonic_range_average_lock_tb;
  import ural_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASE_BEATS  = 243;
  localparam int RAND_PHASES  = 8;

  // one expected result of a burst
  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              forward_locked;
    logic              sensor_healthy;
  } burst_result_t;

  // burst predictor and store of expected results
  class range_scoreboard;
    logic [DIST_W-1:0] threshold;
    logic [SUM_W-1:0]  echo_total;
    logic [CNT_W-1:0]  echo_hits;
    logic [IDX_W-1:0]  burst_pos;
    burst_result_t     expected_q[$];
    int                mismatches;

    function new();
      threshold  = THRESH_RESET;
      echo_total = '0;
      echo_hits  = '0;
      burst_pos  = '0;
      mismatches = 0;
    endfunction

    function void set_threshold(logic [DIST_W-1:0] value);
      threshold = value;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // accumulate one accepted echo beat, predict at the end of a burst
    function void note_echo(logic [ECHO_W-1:0] echo);
      burst_result_t    res;
      logic [SUM_W-1:0] avg;
      logic [31:0]      prod;
      if (echo != '0) begin
        echo_total = echo_total + SUM_W'(echo);
        echo_hits  = echo_hits + CNT_W'(1);
      end
      if (int'(burst_pos) + 1 < SAMPLE_COUNT) begin
        burst_pos = burst_pos + IDX_W'(1);
        return;
      end
      if (echo_hits == '0) begin
        res.distance       = '0;
        res.forward_locked = 1'b1;
        res.sensor_healthy = 1'b0;
      end else begin
        avg                = echo_total / SUM_W'(echo_hits);
        prod               = 32'(avg) * 32'd1124;
        res.distance       = DIST_W'(prod >> 12);
        res.forward_locked = (res.distance < threshold);
        res.sensor_healthy = 1'b1;
      end
      expected_q.push_back(res);
      echo_total = '0;
      echo_hits  = '0;
      burst_pos  = '0;
    endfunction

    // compare one accepted result beat with the oldest expectation
    function void check_result(logic [DIST_W-1:0] got_dist, logic locked, logic healthy);
      burst_result_t exp_res;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: distance %0d locked %0b healthy %0b",
                   got_dist, locked, healthy);
        return;
      end
      exp_res = expected_q.pop_front();
      if (exp_res.distance !== got_dist || exp_res.forward_locked !== locked ||
          exp_res.sensor_healthy !== healthy) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch: expected distance %0d locked %0b healthy %0b, %s",
                   exp_res.distance, exp_res.forward_locked, exp_res.sensor_healthy,
                   $sformatf("got %0d %0b %0b", got_dist, locked, healthy));
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [ECHO_W-1:0] in_echo_us;
  logic              out_valid;
  logic              out_ready;
  logic [DIST_W-1:0] out_distance;
  logic              out_forward_locked;
  logic              out_sensor_healthy;
  logic              cfg_wr_en;
  logic [DIST_W-1:0] cfg_wr_data;

  range_scoreboard sb;
  bit              no_idle;
  int              cycles;

  ultrasonic_range_average_lock u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_echo_us         (in_echo_us),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_distance       (out_distance),
    .out_forward_locked (out_forward_locked),
    .out_sensor_healthy (out_sensor_healthy),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data)
  );

  // 10 ns clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // beat monitor on both channels
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready)
        sb.note_echo(in_echo_us);
      if (out_valid && out_ready)
        sb.check_result(out_distance, out_forward_locked, out_sensor_healthy);
    end
  end

  // result side back-pressure
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 38);
    end
  end

  // drive one echo beat and hold it until accepted
  task automatic send_echo(input logic [ECHO_W-1:0] echo);
    while (!no_idle && $urandom_range(0, 99) < 38) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid   <= 1'b1;
    in_echo_us <= echo;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_burst(input logic [ECHO_W-1:0] e0, input logic [ECHO_W-1:0] e1,
                            input logic [ECHO_W-1:0] e2);
    send_echo(e0);
    send_echo(e1);
    send_echo(e2);
  endtask

  // stop sending, let every result drain, then write the threshold
  task automatic write_threshold(input logic [DIST_W-1:0] value);
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_threshold(value);
  endtask

  // random echo: timeouts, full range, above range, tiny and typical values
  function automatic logic [ECHO_W-1:0] pick_echo();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15)
      return '0;
    else if (r < 25)
      return ECHO_W'($urandom_range(0, 32767));
    else if (r < 32)
      return ECHO_W'($urandom_range(30000, 32767));
    else if (r < 37)
      return ECHO_W'($urandom_range(1, 16));
    else
      return ECHO_W'($urandom_range(100, 30000));
  endfunction

  initial begin
    logic [DIST_W-1:0] thr;
    sb          = new();
    no_idle     = 1'b0;
    cycles      = 0;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_echo_us  = '0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed bursts at the reset threshold
    send_burst(15'd0, 15'd0, 15'd0);               // every echo timed out
    send_burst(15'd32767, 15'd32767, 15'd32767);   // largest average, above range
    send_burst(15'd1, 15'd0, 15'd0);               // one tiny echo
    send_burst(15'd0, 15'd30000, 15'd0);           // top of range, single hit
    send_burst(15'h5555, 15'h2AAA, 15'h7FFF);
    send_burst(15'd1750, 15'd0, 15'd1750);         // distance equal to threshold
    send_burst(15'd1749, 15'd1749, 15'd1749);      // one below threshold

    // threshold extremes
    write_threshold('0);
    send_burst(15'd1, 15'd1, 15'd1);
    send_burst(15'd0, 15'd0, 15'd0);
    write_threshold(DIST_W'(16383));
    send_burst(15'd32767, 15'd32767, 15'd32767);
    send_burst(15'd30001, 15'd1, 15'd2);
    write_threshold(DIST_W'(8232));
    send_burst(15'd30000, 15'd30000, 15'd30000);

    // random phases, one with no idling on either side
    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0: thr = '0;
        1: thr = DIST_W'(16383);
        2: thr = DIST_W'(8232);
        default: thr = $urandom_range(0, 1) ? DIST_W'($urandom_range(0, 16383))
                                            : DIST_W'($urandom_range(100, 3000));
      endcase
      write_threshold(thr);
      no_idle = (p == 3);
      for (int b = 0; b < PHASE_BEATS / SAMPLE_COUNT; b++) begin
        // some bursts are entirely timed out
        if ($urandom_range(0, 9) == 0)
          send_burst(15'd0, 15'd0, 15'd0);
        else
          send_burst(pick_echo(), pick_echo(), pick_echo());
      end
      no_idle = 1'b0;
    end

    // drain and decide
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== ultrasonic_range_average_lock.f =====
hw/rtl/ural_pkg.sv
hw/rtl/ural_front.sv
hw/rtl/ural_fifo.sv
hw/rtl/ural_back.sv
hw/rtl/ultrasonic_range_average_lock.sv
sim/ultrasonic_range_average_lock_tb.sv
